// File: hw/rtl/ihex_pkg.sv
// Shared types and constants for the Intel HEX record loader.
// Used by the front end, the back end and the top level; depends on nothing.
package ihex_pkg;

  localparam int ADDR_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_BYTES = 2'd1;
  localparam logic [1:0] STATUS_NO_RUN   = 2'd2;

  // Header digit positions: two count digits, four address digits, two type digits.
  localparam logic [2:0] COL_COUNT_LOW = 3'd1;
  localparam logic [2:0] COL_ADDR_END  = 3'd6;
  localparam logic [2:0] COL_LAST      = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SKIP,
    MODE_HEAD,
    MODE_DATA
  } line_mode_t;

  typedef enum logic [2:0] {
    TOK_HEX,
    TOK_COLON,
    TOK_NEWLINE,
    TOK_OTHER,
    TOK_EOI
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] nibble;
  } token_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic [ADDR_W-1:0] run_address;
    logic [ADDR_W-1:0] end_address;
    logic [1:0]        load_status;
  } out_item_t;

endpackage

// File: hw/rtl/ihex_queue.sv
// Small first-in first-out queue of any packed item type.
// Takes its default depth from ihex_pkg; used for the token queue and the result queue.
module ihex_queue #(
  parameter int  DEPTH  = ihex_pkg::QUEUE_DEPTH,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t din,
  input  logic  pop,
  output logic  empty,
  output item_t dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/ihex_front.sv
// Front end: takes characters, classifies them into tokens and queues them.
// Depends on ihex_pkg and ihex_queue.
module ihex_front #(
  parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ihex_pkg::in_item_t item,
  input  logic              pop,
  output logic              empty,
  output ihex_pkg::token_t  token
);

  import ihex_pkg::*;

  token_t     tok_in;
  logic [7:0] c;

  assign c = item.char_code;

  always_comb begin
    tok_in.kind   = TOK_OTHER;
    tok_in.nibble = '0;
    priority if (item.end_of_input) begin
      tok_in.kind = TOK_EOI;
    end else if (c == CHAR_NEWLINE) begin
      tok_in.kind = TOK_NEWLINE;
    end else if (c == CHAR_COLON) begin
      tok_in.kind = TOK_COLON;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      tok_in.kind   = TOK_HEX;
      tok_in.nibble = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // Letters A to F in either case: low three bits plus nine give the value.
      tok_in.kind   = TOK_HEX;
      tok_in.nibble = 4'(c[2:0]) + 4'd9;
    end else begin
      tok_in.kind = TOK_OTHER;
    end
  end

  ihex_queue #(
    .DEPTH  (DEPTH),
    .item_t (token_t)
  ) u_tok_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (tok_in),
    .pop   (pop),
    .empty (empty),
    .dout  (token)
  );

endmodule

// File: hw/rtl/ihex_back.sv
// Back end: record parser that turns tokens into byte writes and the finish summary.
// Depends on ihex_pkg.
module ihex_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_empty,
  output logic                tok_pop,
  input  ihex_pkg::token_t    token,
  input  logic                res_full,
  output logic                res_push,
  output ihex_pkg::out_item_t result
);

  import ihex_pkg::*;

  line_mode_t        mode, mode_next;
  logic [2:0]        column, column_next;
  logic [3:0]        nibble_hold, nibble_hold_next;
  logic [7:0]        byte_count, byte_count_next;
  logic [ADDR_W-1:0] record_address, record_address_next;
  logic [7:0]        record_kind, record_kind_next;
  logic [7:0]        data_index, data_index_next;
  logic [ADDR_W-1:0] run_start, run_start_next;
  logic [ADDR_W-1:0] highest_end, highest_end_next;
  logic              bytes_seen, bytes_seen_next;
  logic              load_done, load_done_next;
  logic              finish;
  logic              take_end;
  logic [ADDR_W-1:0] end_cand;
  logic              is_hex;

  assign is_hex   = (token.kind == TOK_HEX);
  assign end_cand = record_address + ADDR_W'(byte_count) - ADDR_W'(1);

  always_comb begin
    mode_next           = mode;
    column_next         = column;
    nibble_hold_next    = nibble_hold;
    byte_count_next     = byte_count;
    record_address_next = record_address;
    record_kind_next    = record_kind;
    data_index_next     = data_index;
    run_start_next      = run_start;
    highest_end_next    = highest_end;
    bytes_seen_next     = bytes_seen;
    load_done_next      = load_done;
    finish              = 1'b0;
    take_end            = 1'b0;
    res_push            = 1'b0;
    result              = '0;
    tok_pop             = !tok_empty && !res_full;

    if (tok_pop && !load_done) begin
      priority if (token.kind == TOK_EOI) begin
        finish = 1'b1;
      end else if (token.kind == TOK_NEWLINE) begin
        mode_next   = MODE_IDLE;
        column_next = '0;
      end else begin
        unique case (mode)
          MODE_IDLE: begin
            if (token.kind == TOK_COLON) begin
              mode_next           = MODE_HEAD;
              column_next         = '0;
              byte_count_next     = '0;
              record_address_next = '0;
              record_kind_next    = '0;
              data_index_next     = '0;
              nibble_hold_next    = '0;
            end else begin
              mode_next = MODE_SKIP;
            end
          end
          MODE_SKIP: begin
            mode_next = MODE_SKIP;
          end
          MODE_HEAD: begin
            if (!is_hex) begin
              mode_next = MODE_SKIP;
            end else begin
              if (column <= COL_COUNT_LOW) begin
                byte_count_next = {byte_count[3:0], token.nibble};
                if (column == COL_COUNT_LOW && byte_count_next != '0) begin
                  bytes_seen_next = 1'b1;
                end
              end else if (column < COL_ADDR_END) begin
                record_address_next = {record_address[ADDR_W-5:0], token.nibble};
              end else begin
                record_kind_next = {record_kind[3:0], token.nibble};
              end
              if (column == COL_LAST) begin
                column_next = '0;
                if (record_kind_next == REC_EOF) begin
                  mode_next = MODE_SKIP;
                  finish    = 1'b1;
                end else if (record_kind_next == REC_DATA) begin
                  if (run_start == '0) begin
                    run_start_next = record_address;
                  end
                  if (byte_count == '0) begin
                    take_end  = 1'b1;
                    mode_next = MODE_SKIP;
                  end else begin
                    mode_next       = MODE_DATA;
                    data_index_next = '0;
                  end
                end else begin
                  mode_next = MODE_SKIP;
                end
              end else begin
                column_next = column + 3'd1;
              end
            end
          end
          MODE_DATA: begin
            if (!is_hex) begin
              mode_next = MODE_SKIP;
            end else if (column == '0) begin
              nibble_hold_next = token.nibble;
              column_next      = 3'd1;
            end else begin
              column_next          = '0;
              res_push             = 1'b1;
              result.result_kind   = KIND_WRITE;
              result.write_address = record_address + ADDR_W'(data_index);
              result.write_data    = {nibble_hold, token.nibble};
              data_index_next      = data_index + 8'd1;
              if (data_index_next >= byte_count) begin
                take_end  = 1'b1;
                mode_next = MODE_SKIP;
              end
            end
          end
          default: mode_next = MODE_SKIP;
        endcase
      end
    end

    if (take_end && end_cand > highest_end) begin
      highest_end_next = end_cand;
    end

    if (finish) begin
      res_push           = 1'b1;
      load_done_next     = 1'b1;
      result.result_kind = KIND_FINISH;
      result.end_address = highest_end;
      if (!bytes_seen) begin
        result.load_status = STATUS_NO_BYTES;
      end else if (run_start == '0) begin
        result.load_status = STATUS_NO_RUN;
      end else begin
        result.load_status = STATUS_OK;
        result.run_address = run_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      column         <= '0;
      nibble_hold    <= '0;
      byte_count     <= '0;
      record_address <= '0;
      record_kind    <= '0;
      data_index     <= '0;
      run_start      <= '0;
      highest_end    <= '0;
      bytes_seen     <= 1'b0;
      load_done      <= 1'b0;
    end else begin
      mode           <= mode_next;
      column         <= column_next;
      nibble_hold    <= nibble_hold_next;
      byte_count     <= byte_count_next;
      record_address <= record_address_next;
      record_kind    <= record_kind_next;
      data_index     <= data_index_next;
      run_start      <= run_start_next;
      highest_end    <= highest_end_next;
      bytes_seen     <= bytes_seen_next;
      load_done      <= load_done_next;
    end
  end

  // Once the summary has gone out the parser must stay finished until reset.
  assert property (@(posedge clk) disable iff (rst) load_done |=> load_done)
    else $error("load_done cleared without reset");

  assert property (@(posedge clk) disable iff (rst) res_push |-> tok_pop && !load_done)
    else $error("result produced without a token transfer");

  assert property (@(posedge clk) disable iff (rst)
      res_push && result.result_kind == KIND_WRITE |-> mode == MODE_DATA)
    else $error("byte write produced outside a data field");

  assert property (@(posedge clk) disable iff (rst)
      res_push && result.result_kind == KIND_FINISH |=> load_done)
    else $error("summary produced without marking the load finished");

endmodule

// File: hw/rtl/intel_hex_record_loader_core.sv
// Intel HEX record loader: one text character is transferred in per clock cycle while full
// is low, and each data byte of a type 0 record comes out as a byte write, followed by a
// single summary once an EOF record or the end-of-input flag is seen. A character first
// passes through the two-entry token queue behind the classifier. The record parser then
// writes its result straight into the two-entry result queue, from which it is taken. The
// parser's registered state update sets the rate. Stalling the result side fills the
// result queue, then the token queue, and only then raises full.
module intel_hex_record_loader_core #(
  parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ihex_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output ihex_pkg::out_item_t result
);

  import ihex_pkg::*;

  logic      tok_empty;
  logic      tok_pop;
  token_t    token;
  logic      res_full;
  logic      res_push;
  out_item_t res_in;

  ihex_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .pop   (tok_pop),
    .empty (tok_empty),
    .token (token)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .token     (token),
    .res_full  (res_full),
    .res_push  (res_push),
    .result    (res_in)
  );

  ihex_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (out_item_t)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

endmodule
